FILE: design/assert_macros.svh
// Assertion macros shared by the replacement block modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DRR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DRR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/drr_pkg.sv
// Shared constants, codes and controller/datapath structs of the replacement block.
`default_nettype none

package drr_pkg;

   // Request and result field widths
   localparam int FUNC_W        = 1;
   localparam int SET_INDEX_W   = 11;
   localparam int WAY_INDEX_W   = 4;
   localparam int PC_W          = 5;
   localparam int VICTIM_W      = 4;

   // Default geometry
   localparam int DEF_NUM_SETS       = 2048;
   localparam int DEF_NUM_WAYS       = 16;
   localparam int DEF_RRPV_WIDTH     = 2;
   localparam int DEF_DUEL_BITS      = 6;
   localparam int DEF_SELECTOR_WIDTH = 10;
   localparam int DEF_BIMODAL_PERIOD = 32;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_VICTIM = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b1;

   // Controller commands to the datapath
   typedef struct packed {
      logic load_req;   // capture an accepted request
      logic rd_en;      // read the set's row
      logic clear_wr;   // write one row of the clearing pass
      logic commit;     // write back the modified row, update selector
      logic load_rsp;   // capture the victim into the result register
   } drr_cmd_type;

   // Datapath status to the controller
   typedef struct packed {
      logic clear_done; // last row of the clearing pass is being written
      logic is_victim;  // held request is a victim request
   } drr_status_type;

endpackage

`default_nettype wire

FILE: design/drr_if.sv
// Request and result channel interfaces of the replacement block.
`default_nettype none

interface drr_req_if import drr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FUNC_W-1:0]      func;
   logic [SET_INDEX_W-1:0] set_index;
   logic [WAY_INDEX_W-1:0] way_index;
   logic                   was_hit;
   logic [PC_W-1:0]        pc_low_bits;

   modport source (output valid, func, set_index, way_index, was_hit, pc_low_bits,
                   input ready);
   modport sink   (input valid, func, set_index, way_index, was_hit, pc_low_bits,
                   output ready);
endinterface

interface drr_rsp_if import drr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VICTIM_W-1:0] victim_way;

   modport source (output valid, victim_way, input ready);
   modport sink   (input valid, victim_way, output ready);
endinterface

`default_nettype wire

FILE: design/drr_datapath.sv
// Datapath: RRPV row memory, set index reduction, ageing, victim search and selector.
`default_nettype none
`include "assert_macros.svh"

module drr_datapath import drr_pkg::*; #(
   parameter int NUM_SETS       = DEF_NUM_SETS,
   parameter int NUM_WAYS       = DEF_NUM_WAYS,
   parameter int RRPV_WIDTH     = DEF_RRPV_WIDTH,
   parameter int DUEL_BITS      = DEF_DUEL_BITS,
   parameter int SELECTOR_WIDTH = DEF_SELECTOR_WIDTH,
   parameter int BIMODAL_PERIOD = DEF_BIMODAL_PERIOD
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire drr_cmd_type            cmd,
   output      drr_status_type         status,
   input  wire logic [FUNC_W-1:0]      req_func,
   input  wire logic [SET_INDEX_W-1:0] req_set_index,
   input  wire logic [WAY_INDEX_W-1:0] req_way_index,
   input  wire logic                   req_was_hit,
   input  wire logic [PC_W-1:0]        req_pc_low_bits,
   output      logic [VICTIM_W-1:0]    rsp_victim_way
);

   localparam int SET_W      = $clog2(NUM_SETS);
   localparam int ROW_W      = NUM_WAYS * RRPV_WIDTH;
   localparam int NUM_LEVELS = 1 << RRPV_WIDTH;
   localparam int WIDE_W     = (SET_W > SET_INDEX_W) ? SET_W : SET_INDEX_W;
   localparam int WAY_BITS   = $clog2(NUM_WAYS);
   localparam int WAY_CMP_W  = ((WAY_BITS > WAY_INDEX_W) ? WAY_BITS : WAY_INDEX_W) + 1;
   localparam int PC_SPAN    = 1 << PC_W;

   // Reciprocal for the set index reduction; exact for every 11-bit index
   localparam int RECIP_SH   = SET_INDEX_W + 17;
   localparam int RECIP      = ((1 << RECIP_SH) + NUM_SETS - 1) / NUM_SETS;
   localparam int PROD_W     = RECIP_SH + SET_INDEX_W;
   localparam int QN_W       = 2 * SET_INDEX_W + 17;

   localparam logic [RRPV_WIDTH-1:0]     RRPV_TOP = {RRPV_WIDTH{1'b1}};
   localparam logic [SELECTOR_WIDTH-1:0] SEL_TOP  = {SELECTOR_WIDTH{1'b1}};
   localparam logic [SELECTOR_WIDTH-1:0] SEL_MID  = SEL_TOP >> 1;
   localparam logic [SET_W-1:0]          LAST_SET = SET_W'(NUM_SETS - 1);

   // Row memory
   logic [ROW_W-1:0] mem [NUM_SETS];

   // Request registers
   logic [FUNC_W-1:0]      func_ff;
   logic [SET_INDEX_W-1:0] idx_ff;
   logic [SET_INDEX_W-1:0] quot_ff;
   logic [WAY_INDEX_W-1:0] way_ff;
   logic                   hit_ff;
   logic [PC_W-1:0]        pc_ff;

   // Read stage registers
   logic [ROW_W-1:0]       row_ff;
   logic [SET_W-1:0]       set_ff;
   logic                   mru_lead_ff;
   logic                   bim_lead_ff;

   // Control state
   logic [SET_W-1:0]          clr_ff;
   logic [SET_W-1:0]          clr_in;
   logic [SELECTOR_WIDTH-1:0] sel_ff;
   logic [SELECTOR_WIDTH-1:0] sel_in;
   logic [VICTIM_W-1:0]       victim_ff;

   // Combinational
   logic [PROD_W-1:0]         prod;
   logic [QN_W-1:0]           quot_n;
   logic [SET_INDEX_W-1:0]    rem;
   logic [WIDE_W-1:0]         rem_wide;
   logic [SET_W-1:0]          set_addr;
   logic [DUEL_BITS-1:0]      duel_low;
   logic [PC_SPAN-1:0]        bim_zero;
   logic [NUM_LEVELS-1:0]     level_seen;
   logic [RRPV_WIDTH-1:0]     top_val;
   logic [RRPV_WIDTH-1:0]     age_add;
   logic [ROW_W-1:0]          aged_row;
   logic [ROW_W-1:0]          upd_row;
   logic [ROW_W-1:0]          new_row;
   logic [WAY_CMP_W-1:0]      victim_ext;
   logic                      use_mru;
   logic [RRPV_WIDTH-1:0]     ins_val;
   logic [SET_W-1:0]          wr_addr;
   logic [ROW_W-1:0]          wr_row;

   // Quotient estimate of the set index by the set count
   assign prod = PROD_W'(req_set_index) * PROD_W'(RECIP);

   // Remainder: the set actually addressed
   assign quot_n   = QN_W'(quot_ff) * QN_W'(NUM_SETS);
   assign rem      = idx_ff - quot_n[SET_INDEX_W-1:0];
   assign rem_wide = WIDE_W'(rem);
   assign set_addr = rem_wide[SET_W-1:0];
   assign duel_low = rem_wide[DUEL_BITS-1:0];

   // Bimodal zero-insert positions of the PC bits
   for (genvar k = 0; k < PC_SPAN; k++) begin : g_bim
      assign bim_zero[k] = ((k % BIMODAL_PERIOD) == 0);
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         idx_ff  <= req_set_index;
         quot_ff <= prod[PROD_W-1 -: SET_INDEX_W];
         way_ff  <= req_way_index;
         hit_ff  <= req_was_hit;
         pc_ff   <= req_pc_low_bits;
      end
   end

   // Read the set's row and classify the set for dueling
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         row_ff      <= mem[set_addr];
         set_ff      <= set_addr;
         mru_lead_ff <= (duel_low == '0);
         bim_lead_ff <= (duel_low == {DUEL_BITS{1'b1}});
      end
   end

   // Find the largest value, age the row, search the victim
   always_comb begin
      level_seen = '0;
      top_val    = '0;
      victim_ext = '0;
      aged_row   = row_ff;
      for (int w = 0; w < NUM_WAYS; w++) begin
         for (int v = 0; v < NUM_LEVELS; v++) begin
            if (row_ff[w*RRPV_WIDTH +: RRPV_WIDTH] == RRPV_WIDTH'(v)) begin
               level_seen[v] = 1'b1;
            end
         end
      end
      for (int v = 0; v < NUM_LEVELS; v++) begin
         if (level_seen[v]) begin
            top_val = RRPV_WIDTH'(v);
         end
      end
      age_add = RRPV_TOP - top_val;
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged_row[w*RRPV_WIDTH +: RRPV_WIDTH] = row_ff[w*RRPV_WIDTH +: RRPV_WIDTH] + age_add;
      end
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (row_ff[w*RRPV_WIDTH +: RRPV_WIDTH] == top_val) begin
            victim_ext = WAY_CMP_W'(w);
         end
      end
   end

   // Choose the inserted value and patch the accessed way
   always_comb begin
      use_mru = mru_lead_ff || (!bim_lead_ff && (sel_ff < SEL_MID));
      if (hit_ff || use_mru || bim_zero[pc_ff]) begin
         ins_val = '0;
      end else begin
         ins_val = RRPV_TOP - RRPV_WIDTH'(1);
      end
      upd_row = row_ff;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (WAY_CMP_W'(way_ff) == WAY_CMP_W'(w)) begin
            upd_row[w*RRPV_WIDTH +: RRPV_WIDTH] = ins_val;
         end
      end
      new_row = (func_ff == FUNC_VICTIM) ? aged_row : upd_row;
   end

   // Write the memory: clearing pass or write-back
   assign wr_addr = cmd.clear_wr ? clr_ff : set_ff;
   assign wr_row  = cmd.clear_wr ? {ROW_W{1'b1}} : new_row;

   always_ff @(posedge clock) begin
      if (cmd.clear_wr || cmd.commit) begin
         mem[wr_addr] <= wr_row;
      end
   end

   // Advance the clearing counter and the saturating selector
   always_comb begin
      clr_in = clr_ff;
      if (cmd.clear_wr) begin
         clr_in = clr_ff + SET_W'(1);
      end
      sel_in = sel_ff;
      if (cmd.commit && (func_ff == FUNC_UPDATE) && !hit_ff) begin
         if (mru_lead_ff) begin
            if (sel_ff != '0) sel_in = sel_ff - SELECTOR_WIDTH'(1);
         end else if (bim_lead_ff) begin
            if (sel_ff != SEL_TOP) sel_in = sel_ff + SELECTOR_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         sel_ff <= SEL_MID;
      end else begin
         clr_ff <= clr_in;
         sel_ff <= sel_in;
      end
   end

   // Hold the victim for the result channel
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         victim_ff <= victim_ext[VICTIM_W-1:0];
      end
   end

   assign rsp_victim_way    = victim_ff;
   assign status.clear_done = (clr_ff == LAST_SET);
   assign status.is_victim  = (func_ff == FUNC_VICTIM);

   `DRR_ASSERT(a_sel_step, clock, reset, 1'b1 |=> (sel_ff == $past(sel_ff) || sel_ff == $past(sel_ff) + SELECTOR_WIDTH'(1) || sel_ff == $past(sel_ff) - SELECTOR_WIDTH'(1)), "selector moved by more than one")

endmodule

`default_nettype wire

FILE: design/drr_ctrl.sv
// Controller: clearing pass, request sequencing and result handshake.
`default_nettype none
`include "assert_macros.svh"

module drr_ctrl import drr_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_ready,
   output      logic           rsp_valid,
   input  wire logic           rsp_ready,
   output      drr_cmd_type    cmd,
   input  wire drr_status_type status
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_ADDR  = 4'b0100,
      ST_RMW   = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   // Sequence the clearing pass, then each request: capture, read, write back
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_RMW;
         end
         ST_RMW: begin
            if (!status.is_victim) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `DRR_ASSERT(a_rsp_no_overwrite, clock, reset, cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready), "result overwritten before taken")
   `DRR_ASSERT_ALWAYS(a_reset_starts_clear, clock, reset |=> (state_ff == ST_CLEAR), "reset did not start the clearing pass")
   `DRR_ASSERT(a_no_req_in_clear, clock, reset, (state_ff == ST_CLEAR) |-> (!cmd.load_req && !cmd.commit), "request handled during clearing pass")

endmodule

`default_nettype wire

FILE: design/dip_rrip_replacement.sv
// Top level of the set-dueling RRIP replacement block.
//
// Channels: req (sink) takes one request per handshake: func selects a victim
// search (returns victim_way on rsp) or an update after an access (no result).
// rsp (source) returns the victim way of each victim request, in order.
// Each request goes through capture and index reduction, a read of the
// set's row from the single-port row memory, and the row write-back together
// with loading the result register for a victim; a new request is taken only
// after that write-back, so requests do not overlap.
// After reset the block writes every row (NUM_SETS, 2048 by default) to the
// maximum value, one row per cycle, with req.ready low; the policy
// selector resets to its midpoint.
// A victim result waits in its output register while rsp is stalled; the next
// request is still accepted and processed, and only a second victim result
// holds in its write-back cycle until the first is taken.
`default_nettype none

module dip_rrip_replacement import drr_pkg::*; #(
   parameter int NUM_SETS       = DEF_NUM_SETS,
   parameter int NUM_WAYS       = DEF_NUM_WAYS,
   parameter int RRPV_WIDTH     = DEF_RRPV_WIDTH,
   parameter int DUEL_BITS      = DEF_DUEL_BITS,
   parameter int SELECTOR_WIDTH = DEF_SELECTOR_WIDTH,
   parameter int BIMODAL_PERIOD = DEF_BIMODAL_PERIOD
) (
   input wire logic  clock,
   input wire logic  reset,
   drr_req_if.sink   req,
   drr_rsp_if.source rsp
);

   drr_cmd_type    cmd;
   drr_status_type status;

   drr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   drr_datapath #(
      .NUM_SETS       (NUM_SETS),
      .NUM_WAYS       (NUM_WAYS),
      .RRPV_WIDTH     (RRPV_WIDTH),
      .DUEL_BITS      (DUEL_BITS),
      .SELECTOR_WIDTH (SELECTOR_WIDTH),
      .BIMODAL_PERIOD (BIMODAL_PERIOD)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req.func),
      .req_set_index   (req.set_index),
      .req_way_index   (req.way_index),
      .req_was_hit     (req.was_hit),
      .req_pc_low_bits (req.pc_low_bits),
      .rsp_victim_way  (rsp.victim_way)
   );

endmodule

`default_nettype wire
